// File: src/sorted_priority_queue_with_attachments_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Clocked on aclk and silenced while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_WITH_ATTACHMENTS_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_WITH_ATTACHMENTS_TOP_MACROS_SVH
`ifndef SYNTH
`define SPQA_CHECK(lbl, prop) lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
    prop) else $error("spqa check failed");
`define SPQA_NEVER(lbl, cond) lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
    !(cond)) else $error("spqa forbidden condition");
`else
`define SPQA_CHECK(lbl, prop)
`define SPQA_NEVER(lbl, cond)
`endif
`endif

// File: src/spqa_pkg.sv
// ----------------------------------------------------------------------------
// spqa_pkg
// Shared types and codes of the sorted priority queue.
// ----------------------------------------------------------------------------
package spqa_pkg;

    localparam int QUEUE_DEPTH_DEF     = 16;
    localparam int ITEMS_PER_ENTRY_DEF = 8;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_ATTACH = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_EMPTY     = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_LIST_FULL = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_PUT,
        ST_ATT_SCAN,
        ST_POP,
        ST_READ,
        ST_OUT
    } state_t;

endpackage

// File: src/sorted_priority_queue_with_attachments_top.sv
// ----------------------------------------------------------------------------
// Sorted priority queue with attachments
// Input beats carry commands (insert, attach, remove); output beats carry results.
//
// s_ channel: s_tuser = mode; s_tdata = entry_key, rank, item_key.
// m_ channel: one beat per insert or attach, one beat per attachment on remove
//   (a single beat when the popped entry has none); m_tlast marks the final one.
// Entries are kept in rank order in registers; attachment lists live in a
// memory addressed by a physical list slot that each entry owns.
// One scan index walks the entries a slot per cycle:
//   insert  : scan to the insert point, shift and put the entry, then the result register,
//   attach  : scan to the matching entry and append, then the result register,
//   remove  : pop the head entry, then one registered memory read per attachment
//             before each of its beats.
// The block takes one command at a time; s_tready is high only when idle, and
// a finished result may still wait in the output register while the next
// command is taken. If the receiver stalls, the sequencer holds its next beat.
// Reset empties the queue and the list slot allocator; memory contents are
// left as they are, since nothing is read that was not written.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_with_attachments_top_macros.svh"

module sorted_priority_queue_with_attachments_top #(
    parameter int QUEUE_DEPTH     = spqa_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEMS_PER_ENTRY = spqa_pkg::ITEMS_PER_ENTRY_DEF,
    localparam int OCCW  = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_W = 3 + 32 + 8 + 32 + OCCW,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [71:0]       s_tdata,   // entry_key[31:0], rank[39:32], item_key[71:40]
    input  logic [1:0]        s_tuser,   // mode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_TW-1:0] m_tdata,   // status, out_entry_key, out_rank, out_item_key,
                                         // occupancy
    output logic              m_tuser,   // item_valid
    output logic              m_tlast
);

    localparam int IDXW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(ITEMS_PER_ENTRY + 1);
    localparam int AW   = $clog2(QUEUE_DEPTH * ITEMS_PER_ENTRY);

    spqa_pkg::state_t state_reg, state_next;

    logic [1:0]       mode_reg;
    logic [31:0]      ekey_reg;
    logic [7:0]       rank_reg;
    logic [31:0]      ikey_reg;

    logic [31:0]      slot_key_reg  [QUEUE_DEPTH];
    logic [7:0]       slot_rank_reg [QUEUE_DEPTH];
    logic [CNTW-1:0]  slot_cnt_reg  [QUEUE_DEPTH];
    logic [IDXW-1:0]  slot_ptr_reg  [QUEUE_DEPTH];

    logic [31:0]      item_mem [QUEUE_DEPTH * ITEMS_PER_ENTRY];
    logic [IDXW-1:0]  ret_mem  [QUEUE_DEPTH];
    logic [31:0]      rd_data_reg;

    logic [OCCW-1:0]  fill_reg;
    logic [OCCW-1:0]  fresh_reg;
    logic [IDXW-1:0]  ret_rd_reg, ret_wr_reg;
    logic [OCCW-1:0]  idx_reg;
    logic [CNTW-1:0]  n_reg, cnt_hd_reg;
    logic [AW-1:0]    base_reg;

    logic [2:0]       pend_status_reg;
    logic [31:0]      pend_ekey_reg;
    logic [7:0]       pend_rank_reg;
    logic             pend_ivalid_reg, pend_last_reg;

    logic             m_valid_reg, m_user_reg, m_last_reg;
    logic [2:0]       m_status_reg;
    logic [31:0]      m_ekey_reg, m_ikey_reg;
    logic [7:0]       m_rank_reg;
    logic [OCCW-1:0]  m_occ_reg;

    logic             accept, at_end, rank_hit, key_hit, list_full, out_free;
    logic [IDXW-1:0]  cur;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [IDXW-1:0]  alloc_ptr;
    logic             use_fresh;

    assign s_tready  = (state_reg == spqa_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cur       = idx_reg[IDXW-1:0];
    assign at_end    = (idx_reg == fill_reg);
    assign rank_hit  = slot_rank_reg[cur] > rank_reg;
    assign key_hit   = slot_key_reg[cur] == ekey_reg;
    assign list_full = slot_cnt_reg[cur] == CNTW'(ITEMS_PER_ENTRY);
    assign wr_addr   = AW'(slot_ptr_reg[cur]) * AW'(ITEMS_PER_ENTRY) + AW'(slot_cnt_reg[cur]);
    assign rd_addr   = base_reg + AW'(n_reg);
    assign use_fresh = (fresh_reg != OCCW'(QUEUE_DEPTH));
    assign alloc_ptr = use_fresh ? fresh_reg[IDXW-1:0] : ret_mem[ret_rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spqa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spqa_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (s_tuser)
                        spqa_pkg::MODE_INSERT: state_next =
                            (fill_reg == OCCW'(QUEUE_DEPTH)) ? spqa_pkg::ST_OUT
                                                              : spqa_pkg::ST_INS_SCAN;
                        spqa_pkg::MODE_ATTACH: state_next = spqa_pkg::ST_ATT_SCAN;
                        spqa_pkg::MODE_REMOVE: state_next =
                            (fill_reg == '0) ? spqa_pkg::ST_OUT : spqa_pkg::ST_POP;
                        default: state_next = spqa_pkg::ST_IDLE;
                    endcase
                end
            end
            spqa_pkg::ST_INS_SCAN: begin
                if (at_end || rank_hit) state_next = spqa_pkg::ST_INS_PUT;
            end
            spqa_pkg::ST_INS_PUT: state_next = spqa_pkg::ST_OUT;
            spqa_pkg::ST_ATT_SCAN: begin
                if (at_end || key_hit) state_next = spqa_pkg::ST_OUT;
            end
            spqa_pkg::ST_POP: begin
                state_next = (slot_cnt_reg[0] == '0) ? spqa_pkg::ST_OUT : spqa_pkg::ST_READ;
            end
            spqa_pkg::ST_READ: state_next = spqa_pkg::ST_OUT;
            spqa_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = (pend_ivalid_reg && !pend_last_reg) ? spqa_pkg::ST_READ
                                                                      : spqa_pkg::ST_IDLE;
                end
            end
            default: state_next = spqa_pkg::ST_IDLE;
        endcase
    end

    // attachment memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (state_reg == spqa_pkg::ST_ATT_SCAN && !at_end && key_hit && !list_full) begin
            item_mem[wr_addr] <= ikey_reg;
        end
        rd_data_reg <= item_mem[rd_addr];
    end

    // control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            fresh_reg   <= '0;
            ret_rd_reg  <= '0;
            ret_wr_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == spqa_pkg::ST_INS_PUT) begin
                fill_reg <= fill_reg + 1'b1;
                if (use_fresh) begin
                    fresh_reg <= fresh_reg + 1'b1;
                end else begin
                    ret_rd_reg <= (ret_rd_reg == IDXW'(QUEUE_DEPTH - 1)) ? '0
                                                                         : ret_rd_reg + 1'b1;
                end
            end
            if (state_reg == spqa_pkg::ST_POP) begin
                fill_reg   <= fill_reg - 1'b1;
                ret_wr_reg <= (ret_wr_reg == IDXW'(QUEUE_DEPTH - 1)) ? '0 : ret_wr_reg + 1'b1;
            end
            if (state_reg == spqa_pkg::ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg        <= s_tuser;
            ekey_reg        <= s_tdata[31:0];
            rank_reg        <= s_tdata[39:32];
            ikey_reg        <= s_tdata[71:40];
            idx_reg         <= '0;
            pend_ekey_reg   <= '0;
            pend_rank_reg   <= '0;
            pend_ivalid_reg <= 1'b0;
            pend_last_reg   <= 1'b1;
            pend_status_reg <= (s_tuser == spqa_pkg::MODE_INSERT) ? spqa_pkg::STAT_FULL
                                                                  : spqa_pkg::STAT_EMPTY;
        end
        unique case (state_reg)
            spqa_pkg::ST_INS_SCAN: begin
                if (!(at_end || rank_hit)) idx_reg <= idx_reg + 1'b1;
            end
            spqa_pkg::ST_INS_PUT: begin
                // open a hole at the insert point and drop the new entry in
                for (int j = 1; j < QUEUE_DEPTH; j++) begin
                    if (OCCW'(j) > idx_reg && OCCW'(j) <= fill_reg) begin
                        slot_key_reg[j]  <= slot_key_reg[j-1];
                        slot_rank_reg[j] <= slot_rank_reg[j-1];
                        slot_cnt_reg[j]  <= slot_cnt_reg[j-1];
                        slot_ptr_reg[j]  <= slot_ptr_reg[j-1];
                    end
                end
                slot_key_reg[cur]  <= ekey_reg;
                slot_rank_reg[cur] <= rank_reg;
                slot_cnt_reg[cur]  <= '0;
                slot_ptr_reg[cur]  <= alloc_ptr;
                pend_status_reg    <= spqa_pkg::STAT_OK;
            end
            spqa_pkg::ST_ATT_SCAN: begin
                if (at_end) begin
                    pend_status_reg <= spqa_pkg::STAT_NOT_FOUND;
                end else if (key_hit) begin
                    if (list_full) begin
                        pend_status_reg <= spqa_pkg::STAT_LIST_FULL;
                    end else begin
                        slot_cnt_reg[cur] <= slot_cnt_reg[cur] + 1'b1;
                        pend_status_reg   <= spqa_pkg::STAT_OK;
                    end
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            spqa_pkg::ST_POP: begin
                base_reg        <= AW'(slot_ptr_reg[0]) * AW'(ITEMS_PER_ENTRY);
                cnt_hd_reg      <= slot_cnt_reg[0];
                n_reg           <= '0;
                pend_status_reg <= spqa_pkg::STAT_OK;
                pend_ekey_reg   <= slot_key_reg[0];
                pend_rank_reg   <= slot_rank_reg[0];
                pend_ivalid_reg <= (slot_cnt_reg[0] != '0);
                pend_last_reg   <= (slot_cnt_reg[0] <= CNTW'(1));
                ret_mem[ret_wr_reg] <= slot_ptr_reg[0];
                for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                    slot_key_reg[j]  <= slot_key_reg[j+1];
                    slot_rank_reg[j] <= slot_rank_reg[j+1];
                    slot_cnt_reg[j]  <= slot_cnt_reg[j+1];
                    slot_ptr_reg[j]  <= slot_ptr_reg[j+1];
                end
            end
            spqa_pkg::ST_OUT: begin
                if (out_free) begin
                    m_status_reg <= pend_status_reg;
                    m_ekey_reg   <= pend_ekey_reg;
                    m_rank_reg   <= pend_rank_reg;
                    m_ikey_reg   <= pend_ivalid_reg ? rd_data_reg : 32'd0;
                    m_user_reg   <= pend_ivalid_reg;
                    m_last_reg   <= pend_last_reg;
                    m_occ_reg    <= fill_reg;
                    // advance to the next attachment of the popped entry
                    if (pend_ivalid_reg && !pend_last_reg) begin
                        n_reg         <= n_reg + 1'b1;
                        pend_last_reg <= ({1'b0, n_reg} + (CNTW+1)'(2)) == {1'b0, cnt_hd_reg};
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OUT_TW'({m_occ_reg, m_ikey_reg, m_rank_reg, m_ekey_reg, m_status_reg});

    `SPQA_NEVER(a_fill_bound, fill_reg > OCCW'(QUEUE_DEPTH))
    `SPQA_CHECK(a_ins_grow, (state_reg == spqa_pkg::ST_INS_PUT) |=> (fill_reg == $past(fill_reg) + 1'b1))
    `SPQA_CHECK(a_pop_shrink, (state_reg == spqa_pkg::ST_POP) |=> (fill_reg == $past(fill_reg) - 1'b1))
    `SPQA_NEVER(a_attach_mode, (state_reg == spqa_pkg::ST_ATT_SCAN) && (mode_reg != spqa_pkg::MODE_ATTACH))

endmodule
